/* hw/rtl/sacc_pkg.sv */
// Shared types and constants for the sixteen-bit accumulator CPU.
`default_nettype none

package sacc_pkg;

	localparam int MEM_WORDS = 4096;
	localparam int ADDR_W    = $clog2(MEM_WORDS);
	localparam int PC_W      = ADDR_W + 1;
	localparam int WORD_W    = 16;
	localparam int OP_W      = 4;

	// request kinds
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_EXEC    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// opcodes
	localparam logic [OP_W-1:0] OP_JNS    = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OP_W-1:0] OP_STORE  = 4'd2;
	localparam logic [OP_W-1:0] OP_ADD    = 4'd3;
	localparam logic [OP_W-1:0] OP_SUBT   = 4'd4;
	localparam logic [OP_W-1:0] OP_INPUT  = 4'd5;
	localparam logic [OP_W-1:0] OP_OUTPUT = 4'd6;
	localparam logic [OP_W-1:0] OP_HALT   = 4'd7;
	localparam logic [OP_W-1:0] OP_SKIP   = 4'd8;
	localparam logic [OP_W-1:0] OP_JUMP   = 4'd9;
	localparam logic [OP_W-1:0] OP_CLEAR  = 4'd10;
	localparam logic [OP_W-1:0] OP_ADDI   = 4'd11;
	localparam logic [OP_W-1:0] OP_JUMPI  = 4'd12;
	localparam logic [OP_W-1:0] OP_LOADI  = 4'd13;
	localparam logic [OP_W-1:0] OP_STOREI = 4'd14;

	// skipcond condition codes
	localparam logic [ADDR_W-1:0] SKIP_NEG  = 12'h000;
	localparam logic [ADDR_W-1:0] SKIP_ZERO = 12'h400;
	localparam logic [ADDR_W-1:0] SKIP_POS  = 12'h800;

	localparam logic [PC_W-1:0] PC_END = PC_W'(MEM_WORDS);

	typedef struct packed {
		logic [1:0]               kind;
		logic [ADDR_W-1:0]        load_address;
		logic [WORD_W-1:0]        load_data;
		logic signed [WORD_W-1:0] in_value;
	} req_t;

	typedef struct packed {
		logic [PC_W-1:0]          pc_now;
		logic signed [WORD_W-1:0] acc_now;
		logic                     out_valid;
		logic signed [WORD_W-1:0] out_value;
		logic                     took_input;
		logic                     halted;
	} res_t;

endpackage

`default_nettype wire

/* hw/rtl/sacc_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none

module sacc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/sixteen_bit_accumulator_cpu.sv */
// Top level of the sixteen-bit accumulator CPU: sequencer, registers and main memory.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in      | to block  | in_valid / in_stall | in_data  (sacc_pkg::req_t)
//  out     | from block| out_valid/out_stall | out_data (sacc_pkg::res_t)
//  cfg     | to block  | cfg_we              | cfg_wdata (start address)
//
// Load, restart and non-executing requests pass only through accept and result. An
// instruction adds a fetch state and one state per dependent read of the single-read-port
// main memory: none without an operand read (Store and JnS write during the fetch), S_OPER
// for Load, Add, Subt, JumpI and StoreI, S_OPER and S_IND for AddI and LoadI. After reset
// the memory is swept to zero, one word per cycle, with in_stall high. A result waiting
// on out_stall does not block the next request; the one after that waits.
`default_nettype none

module sixteen_bit_accumulator_cpu (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire sacc_pkg::req_t                in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output sacc_pkg::res_t                     out_data,
	input  wire logic                          cfg_we,
	input  wire logic [sacc_pkg::ADDR_W-1:0]   cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_OPER  = 3'd2;
	localparam logic [2:0] S_IND   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                        state_q;
	logic                              clr_busy_q;
	logic [sacc_pkg::ADDR_W-1:0]       clr_cnt_q;
	logic [sacc_pkg::ADDR_W-1:0]       start_q;
	logic [sacc_pkg::PC_W-1:0]         pc_q;
	logic [sacc_pkg::WORD_W-1:0]       acc_q;
	logic                              halt_q;
	logic [sacc_pkg::OP_W-1:0]         op_q;
	logic signed [sacc_pkg::WORD_W-1:0] in_value_q;
	logic                              ov_q;
	logic [sacc_pkg::WORD_W-1:0]       oval_q;
	logic                              ti_q;
	logic                              res_vld_q;
	sacc_pkg::res_t                    res_q;

	logic                              ram_we;
	logic [sacc_pkg::ADDR_W-1:0]       ram_waddr;
	logic [sacc_pkg::WORD_W-1:0]       ram_wdata;
	logic [sacc_pkg::ADDR_W-1:0]       ram_raddr;
	logic [sacc_pkg::WORD_W-1:0]       ram_rdata;

	logic                              accept;
	logic                              res_load;
	logic [sacc_pkg::OP_W-1:0]         f_op;
	logic [sacc_pkg::ADDR_W-1:0]       f_x;
	logic [sacc_pkg::PC_W-1:0]         pc_inc;
	logic [sacc_pkg::PC_W-1:0]         pc_skip;
	logic                              acc_neg;
	logic                              acc_zero;
	logic                              do_skip;
	logic                              fetch_oper;
	logic [sacc_pkg::PC_W-1:0]         pc_fetch;

	assign accept   = in_valid && !in_stall;
	assign in_stall = clr_busy_q || (state_q != S_IDLE);
	assign res_load = (state_q == S_DONE) && (!res_vld_q || !out_stall);

	assign f_op     = ram_rdata[sacc_pkg::WORD_W-1 -: sacc_pkg::OP_W];
	assign f_x      = ram_rdata[sacc_pkg::ADDR_W-1:0];
	assign pc_inc   = pc_q + sacc_pkg::PC_W'(1);
	assign pc_skip  = pc_q + sacc_pkg::PC_W'(2);
	assign acc_neg  = acc_q[sacc_pkg::WORD_W-1];
	assign acc_zero = (acc_q == '0);
	assign do_skip  = ((f_x == sacc_pkg::SKIP_NEG) && acc_neg)
		|| ((f_x == sacc_pkg::SKIP_ZERO) && acc_zero)
		|| ((f_x == sacc_pkg::SKIP_POS) && !acc_neg && !acc_zero);

	// next program counter and operand need of the fetched word
	always_comb begin
		fetch_oper = 1'b0;
		pc_fetch   = pc_inc;
		case (f_op)
			sacc_pkg::OP_JNS: begin
				if (f_x != '0) begin
					pc_fetch = sacc_pkg::PC_W'(f_x) + sacc_pkg::PC_W'(1);
				end
			end
			sacc_pkg::OP_LOAD, sacc_pkg::OP_ADD, sacc_pkg::OP_SUBT,
			sacc_pkg::OP_ADDI, sacc_pkg::OP_JUMPI, sacc_pkg::OP_LOADI,
			sacc_pkg::OP_STOREI: begin
				fetch_oper = 1'b1;
			end
			sacc_pkg::OP_HALT: begin
				pc_fetch = sacc_pkg::PC_END;
			end
			sacc_pkg::OP_SKIP: begin
				if (do_skip) begin
					// saturate at end of memory
					pc_fetch = (pc_skip > sacc_pkg::PC_END) ? sacc_pkg::PC_END : pc_skip;
				end
			end
			sacc_pkg::OP_JUMP: begin
				pc_fetch = sacc_pkg::PC_W'(f_x);
			end
			default: begin
			end
		endcase
	end

	// memory port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = '0;
		ram_raddr = pc_q[sacc_pkg::ADDR_W-1:0];
		if (clr_busy_q) begin
			ram_we = 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_data.kind == sacc_pkg::KIND_LOAD) begin
						ram_we    = 1'b1;
						ram_waddr = in_data.load_address;
						ram_wdata = in_data.load_data;
					end
				end
				S_FETCH: begin
					ram_raddr = f_x;
					if (f_op == sacc_pkg::OP_JNS && f_x != '0) begin
						ram_we    = 1'b1;
						ram_waddr = f_x;
						ram_wdata = sacc_pkg::WORD_W'(pc_inc);
					end else if (f_op == sacc_pkg::OP_STORE) begin
						ram_we    = 1'b1;
						ram_waddr = f_x;
						ram_wdata = acc_q;
					end
				end
				S_OPER: begin
					ram_raddr = ram_rdata[sacc_pkg::ADDR_W-1:0];
					if (op_q == sacc_pkg::OP_STOREI) begin
						ram_we    = 1'b1;
						ram_waddr = ram_rdata[sacc_pkg::ADDR_W-1:0];
						ram_wdata = acc_q;
					end
				end
				S_IND, S_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	sacc_ram #(
		.WIDTH(sacc_pkg::WORD_W),
		.DEPTH(sacc_pkg::MEM_WORDS)
	) u_mem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			start_q    <= '0;
			pc_q       <= '0;
			acc_q      <= '0;
			halt_q     <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + sacc_pkg::ADDR_W'(1);
				if (&clr_cnt_q) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (out_valid && !out_stall) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.kind == sacc_pkg::KIND_EXEC
							&& !halt_q && !pc_q[sacc_pkg::PC_W-1]) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_DONE;
						end
						if (in_data.kind == sacc_pkg::KIND_RESTART) begin
							pc_q   <= sacc_pkg::PC_W'(start_q);
							acc_q  <= '0;
							halt_q <= 1'b0;
						end
					end
				end
				S_FETCH: begin
					state_q <= fetch_oper ? S_OPER : S_DONE;
					pc_q    <= pc_fetch;
					if (f_op == sacc_pkg::OP_INPUT) begin
						acc_q <= in_value_q;
					end else if (f_op == sacc_pkg::OP_CLEAR) begin
						acc_q <= '0;
					end
					if (f_op == sacc_pkg::OP_HALT) begin
						halt_q <= 1'b1;
					end
				end
				S_OPER: begin
					if (op_q == sacc_pkg::OP_ADDI || op_q == sacc_pkg::OP_LOADI) begin
						state_q <= S_IND;
					end else begin
						state_q <= S_DONE;
					end
					case (op_q)
						sacc_pkg::OP_LOAD:  acc_q <= ram_rdata;
						sacc_pkg::OP_ADD:   acc_q <= acc_q + ram_rdata;
						sacc_pkg::OP_SUBT:  acc_q <= acc_q - ram_rdata;
						sacc_pkg::OP_JUMPI: pc_q  <= sacc_pkg::PC_W'(ram_rdata[sacc_pkg::ADDR_W-1:0]);
						default: begin
						end
					endcase
				end
				S_IND: begin
					state_q <= S_DONE;
					if (op_q == sacc_pkg::OP_ADDI) begin
						acc_q <= acc_q + ram_rdata;
					end else begin
						acc_q <= ram_rdata;
					end
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-request payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			in_value_q <= in_data.in_value;
			ov_q       <= 1'b0;
			oval_q     <= '0;
			ti_q       <= 1'b0;
		end else if (state_q == S_FETCH) begin
			if (f_op == sacc_pkg::OP_INPUT) begin
				ti_q <= 1'b1;
			end
			if (f_op == sacc_pkg::OP_OUTPUT) begin
				ov_q   <= 1'b1;
				oval_q <= acc_q;
			end
		end
		if (state_q == S_FETCH) begin
			op_q <= f_op;
		end
		if (res_load) begin
			res_q.pc_now     <= pc_q;
			res_q.acc_now    <= acc_q;
			res_q.out_valid  <= ov_q;
			res_q.out_value  <= oval_q;
			res_q.took_input <= ti_q;
			res_q.halted     <= halt_q || pc_q[sacc_pkg::PC_W-1];
		end
	end

	assign out_valid = res_vld_q;
	assign out_data  = res_q;

endmodule

`default_nettype wire
